@@ design/abas_pkg.sv @@
// ----------------------------------------------------------------------------
// abas_pkg
// Shared types, codes and defaults for the arena bump allocator with scopes.
// ----------------------------------------------------------------------------
`default_nettype none

package abas_pkg;

  // Default sizing
  localparam int SCOPE_DEPTH_DEF     = 8;
  localparam int TABLE_ENTRIES_DEF   = 16;
  localparam int BYTE_COUNT_BITS_DEF = 32;

  // Operation codes
  localparam logic [2:0] MODE_ALLOC      = 3'd0;
  localparam logic [2:0] MODE_MARK       = 3'd1;
  localparam logic [2:0] MODE_RESET      = 3'd2;
  localparam logic [2:0] MODE_BEGIN      = 3'd3;
  localparam logic [2:0] MODE_END        = 3'd4;
  localparam logic [2:0] MODE_CLEAR      = 3'd5;
  localparam logic [2:0] MODE_READ       = 3'd6;

  // Status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_CAPACITY     = 3'd1;
  localparam logic [2:0] ST_MARK_AHEAD   = 3'd2;
  localparam logic [2:0] ST_STACK_FULL   = 3'd3;
  localparam logic [2:0] ST_NO_SCOPE     = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL   = 3'd5;

  // Register indexes
  localparam logic [0:0] REG_CAPACITY    = 1'd0;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] request_size;
    logic [15:0] alignment;
    logic [31:0] mark_value;
    logic [7:0]  scope_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] offset;
    logic [31:0] used_now;
    logic [31:0] peak_now;
    logic        entry_found;
    logic [31:0] invocations;
    logic [31:0] entry_peak_delta;
    logic [31:0] entry_peak_used;
    logic [31:0] entry_alloc_count;
  } out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic alloc;
    logic merge;
    logic srch_rd;
    logic srch_next;
    logic take;
    logic tbl_write;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] mode;
    logic       stack_empty;
    logic       id_zero;
    logic       div_last;
    logic       srch_end;
    logic       srch_hit;
  } sts_t;

endpackage

`default_nettype wire

@@ design/arena_bump_allocator_scopes_unit.sv @@
// ----------------------------------------------------------------------------
// arena_bump_allocator_scopes_unit
// Bump-pointer arena allocator with a scope stack and per-scope telemetry.
// ----------------------------------------------------------------------------
// Usage:
//   A word on in_data is taken at a rising edge with start high and busy low.
//   Its result appears on out_data for exactly one cycle with out_valid high;
//   the receiver cannot stall, and a new word may start in that same cycle.
//   Rollback, reset, begin, clear, an unnamed read and an end on an empty
//   stack finish straight from execute. Allocate first runs the bit-serial
//   remainder divider. An end on a non-empty stack folds the popped scope
//   into its parent; it and a named read then search the telemetry table
//   RAM entry by entry. End scope then updates the found entry, appends a
//   new one, or reports the table full.
//   The capacity register sits at byte address 0 of the APB port; write it
//   only while the block is idle. pready is tied high.
//   Reset clears usage, peak, the scope stack pointer, the table fill count
//   and capacity. Stack and table RAMs are not cleared; only filled entries
//   are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module arena_bump_allocator_scopes_unit #(
  parameter int SCOPE_DEPTH     = abas_pkg::SCOPE_DEPTH_DEF,
  parameter int TABLE_ENTRIES   = abas_pkg::TABLE_ENTRIES_DEF,
  parameter int BYTE_COUNT_BITS = abas_pkg::BYTE_COUNT_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire abas_pkg::in_t  in_data,
  output logic                out_valid,
  output abas_pkg::out_t      out_data,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [2:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import abas_pkg::*;

  logic [BYTE_COUNT_BITS-1:0] cap_r;
  logic                       cfg_hit;
  cmd_t                       cmd;
  sts_t                       sts;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_CAPACITY) && (paddr[1:0] == 2'b00);
  assign prdata  = cfg_hit ? 32'(cap_r) : 32'd0;

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '0;
    end else if (psel && penable && pwrite && cfg_hit) begin
      cap_r <= BYTE_COUNT_BITS'(pwdata);
    end
  end

  abas_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  abas_dpath #(
    .SCOPE_DEPTH     (SCOPE_DEPTH),
    .TABLE_ENTRIES   (TABLE_ENTRIES),
    .BYTE_COUNT_BITS (BYTE_COUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cap       (cap_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not make the block busy");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.entry_found |-> out_data.status == ST_OK)
    else $error("telemetry hit reported with an error status");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a word in progress");
`endif

endmodule

`default_nettype wire

@@ design/abas_ram.sv @@
// ----------------------------------------------------------------------------
// abas_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module abas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write, then registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/abas_ctrl.sv @@
// ----------------------------------------------------------------------------
// abas_ctrl
// Sequencer: steps each word through execute and, by mode, divide, merge and table search.
// ----------------------------------------------------------------------------
`default_nettype none

module abas_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  input  wire abas_pkg::sts_t sts,
  output abas_pkg::cmd_t      cmd
);
  import abas_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_MERGE = 3'd4;
  localparam logic [2:0] S_SRD   = 3'd5;
  localparam logic [2:0] S_SCMP  = 3'd6;
  localparam logic [2:0] S_TWR   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.mode == MODE_ALLOC) begin
          state_nxt = S_DIV;
        end else if (sts.mode == MODE_END) begin
          if (sts.stack_empty) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_MERGE;
          end
        end else if (sts.mode == MODE_READ && !sts.id_zero) begin
          state_nxt = S_SRD;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = S_SRD;
      end
      S_SRD: begin
        if (sts.srch_end) begin
          if (sts.mode == MODE_READ) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_TWR;
          end
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sts.srch_hit) begin
          cmd.take = 1'b1;
          if (sts.mode == MODE_READ) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_TWR;
          end
        end else begin
          cmd.srch_next = 1'b1;
          state_nxt     = S_SRD;
        end
      end
      S_TWR: begin
        cmd.tbl_write = 1'b1;
        cmd.finish    = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ design/abas_dpath.sv @@
// ----------------------------------------------------------------------------
// abas_dpath
// Datapath: usage counters, remainder divider, scope stack and telemetry table.
// ----------------------------------------------------------------------------
`default_nettype none

module abas_dpath #(
  parameter int SCOPE_DEPTH     = 8,
  parameter int TABLE_ENTRIES   = 16,
  parameter int BYTE_COUNT_BITS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire abas_pkg::in_t              in_data,
  input  wire logic [BYTE_COUNT_BITS-1:0] cap,
  input  wire abas_pkg::cmd_t             cmd,
  output abas_pkg::sts_t                  sts,
  output abas_pkg::out_t                  out_data,
  output logic                            out_valid
);
  import abas_pkg::*;

  localparam int BW   = BYTE_COUNT_BITS;
  localparam int TOPW = $clog2(SCOPE_DEPTH + 1);
  localparam int SAW  = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;
  localparam int TCW  = $clog2(TABLE_ENTRIES + 1);
  localparam int TAW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int DCW  = $clog2(BW);
  localparam int SUMW = ((BW > 32) ? BW : 32) + 2;
  localparam int SW   = 8 + BW + BW + 32;
  localparam int TW   = 8 + 32 + BW + BW + 32;
  localparam logic [31:0] CNT_MAX = '1;

  // Latched word
  logic [2:0]  mode_r;
  logic [31:0] size_r;
  logic [15:0] align_r;
  logic [BW-1:0] mark_r;
  logic [7:0]  id_r;

  // Arena state
  logic [BW-1:0]   used_r, used_nxt, peak_r, peak_nxt;
  logic [TOPW-1:0] top_r, top_nxt;
  logic [7:0]      tid_r, tid_nxt, pid_r;
  logic [BW-1:0]   tentry_r, tentry_nxt, tpeak_r, tpeak_nxt, pentry_r, ppeak_r;
  logic [31:0]     tcnt_r, tcnt_nxt, pcnt_r;
  logic [TCW-1:0]  tcount_r, tcount_nxt, idx_r;
  logic            hit_r;

  // Divider
  logic [15:0]   rem_r;
  logic [BW-1:0] dq_r;
  logic [DCW-1:0] dcnt_r;
  logic [16:0]   dvs, dtrial;

  // Result
  logic [2:0]  status_r, status_nxt;
  logic [31:0] offset_r, offset_nxt;
  logic        found_r, found_nxt;
  logic [31:0] e_inv_r, e_inv_nxt, e_delta_r, e_delta_nxt;
  logic [31:0] e_used_r, e_used_nxt, e_cnt_r, e_cnt_nxt;
  out_t        out_r;
  logic        out_valid_r;

  // Stack and table ports
  logic          s_we, s_re;
  logic [SAW-1:0] s_waddr, s_raddr;
  logic [SW-1:0] s_wdata, s_rdata;
  logic          t_we, t_re;
  logic [TAW-1:0] t_waddr;
  logic [TW-1:0] t_wdata, t_rdata;

  // Unpacked views
  logic [7:0]    s_rid, t_rid;
  logic [BW-1:0] s_rentry, s_rpeak, t_rdelta, t_rpused, delta;
  logic [31:0]   s_rcnt, t_rinv, t_rcnt;
  logic [32:0]   cnt_sum;
  logic [BW:0]   aligned;
  logic [SUMW-1:0] need;
  logic          fits;
  logic [7:0]    key;

  assign {s_rid, s_rentry, s_rpeak, s_rcnt} = s_rdata;
  assign {t_rid, t_rinv, t_rdelta, t_rpused, t_rcnt} = t_rdata;

  // Divisor and restoring step
  assign dvs    = (align_r == 16'd0) ? 17'd1 : {1'b0, align_r};
  assign dtrial = {rem_r, dq_r[BW-1]};

  // Allocation arithmetic
  assign aligned = (rem_r == 16'd0) ? {1'b0, used_r}
                 : (BW+1)'({1'b0, used_r} + (BW+1)'(dvs) - (BW+1)'(rem_r));
  assign need    = SUMW'(aligned) + SUMW'(size_r);
  assign fits    = (need <= SUMW'(cap));

  assign cnt_sum = {1'b0, s_rcnt} + {1'b0, pcnt_r};
  assign delta   = (ppeak_r >= pentry_r) ? (ppeak_r - pentry_r) : '0;
  assign key     = (mode_r == MODE_READ) ? id_r : pid_r;

  // Status to sequencer
  assign sts.mode        = mode_r;
  assign sts.stack_empty = (top_r == '0);
  assign sts.id_zero     = (id_r == 8'd0);
  assign sts.div_last    = (dcnt_r == DCW'(BW - 1));
  assign sts.srch_end    = (idx_r == tcount_r);
  assign sts.srch_hit    = (t_rid == key);

  // Operation logic
  always_comb begin
    used_nxt    = used_r;
    peak_nxt    = peak_r;
    top_nxt     = top_r;
    tid_nxt     = tid_r;
    tentry_nxt  = tentry_r;
    tpeak_nxt   = tpeak_r;
    tcnt_nxt    = tcnt_r;
    tcount_nxt  = tcount_r;
    status_nxt  = status_r;
    offset_nxt  = offset_r;
    found_nxt   = found_r;
    e_inv_nxt   = e_inv_r;
    e_delta_nxt = e_delta_r;
    e_used_nxt  = e_used_r;
    e_cnt_nxt   = e_cnt_r;
    s_we    = 1'b0;
    s_re    = 1'b0;
    s_waddr = SAW'(top_r - TOPW'(1));
    s_raddr = SAW'(top_r - TOPW'(2));
    s_wdata = {tid_r, tentry_r, tpeak_r, tcnt_r};
    t_we    = 1'b0;
    t_re    = cmd.srch_rd;
    t_waddr = hit_r ? idx_r[TAW-1:0] : tcount_r[TAW-1:0];
    t_wdata = {pid_r, 32'd1, delta, ppeak_r, pcnt_r};

    if (cmd.load) begin
      status_nxt  = ST_OK;
      offset_nxt  = '0;
      found_nxt   = 1'b0;
      e_inv_nxt   = '0;
      e_delta_nxt = '0;
      e_used_nxt  = '0;
      e_cnt_nxt   = '0;
    end

    if (cmd.exec) begin
      unique case (mode_r)
        MODE_MARK: begin
          if (mark_r > used_r) begin
            status_nxt = ST_MARK_AHEAD;
          end else begin
            used_nxt = mark_r;
          end
        end
        MODE_RESET: used_nxt = '0;
        MODE_BEGIN: begin
          if (id_r != 8'd0) begin
            if (top_r == TOPW'(SCOPE_DEPTH)) begin
              status_nxt = ST_STACK_FULL;
            end else begin
              s_we       = (top_r != '0);
              tid_nxt    = id_r;
              tentry_nxt = used_r;
              tpeak_nxt  = used_r;
              tcnt_nxt   = '0;
              top_nxt    = top_r + TOPW'(1);
            end
          end
        end
        MODE_END: begin
          if (top_r == '0) begin
            status_nxt = ST_NO_SCOPE;
          end else begin
            s_re    = 1'b1;
            top_nxt = top_r - TOPW'(1);
          end
        end
        MODE_CLEAR: tcount_nxt = '0;
        default: ;
      endcase
    end

    // Check capacity, then grant and bump usage, peak and the top scope
    if (cmd.alloc) begin
      if (!fits) begin
        status_nxt = ST_CAPACITY;
      end else begin
        offset_nxt = 32'(aligned);
        used_nxt   = BW'(need);
        if (BW'(need) > peak_r) begin
          peak_nxt = BW'(need);
        end
        if (top_r != '0) begin
          if (BW'(need) > tpeak_r) begin
            tpeak_nxt = BW'(need);
          end
          if (tcnt_r != CNT_MAX) begin
            tcnt_nxt = tcnt_r + 32'd1;
          end
        end
      end
    end

    // Fold the popped scope into its parent
    if (cmd.merge && top_r != '0) begin
      tid_nxt    = s_rid;
      tentry_nxt = s_rentry;
      tpeak_nxt  = (s_rpeak > ppeak_r) ? s_rpeak : ppeak_r;
      tcnt_nxt   = cnt_sum[32] ? CNT_MAX : cnt_sum[31:0];
    end

    if (cmd.take && mode_r == MODE_READ) begin
      found_nxt   = 1'b1;
      e_inv_nxt   = t_rinv;
      e_delta_nxt = 32'(t_rdelta);
      e_used_nxt  = 32'(t_rpused);
      e_cnt_nxt   = t_rcnt;
    end

    // Update or append the telemetry entry, or flag a full table
    if (cmd.tbl_write) begin
      if (hit_r) begin
        t_we    = 1'b1;
        t_wdata = {t_rid,
                   (t_rinv == CNT_MAX) ? t_rinv : t_rinv + 32'd1,
                   (t_rdelta > delta) ? t_rdelta : delta,
                   (t_rpused > ppeak_r) ? t_rpused : ppeak_r,
                   (t_rcnt > pcnt_r) ? t_rcnt : pcnt_r};
      end else if (tcount_r == TCW'(TABLE_ENTRIES)) begin
        status_nxt = ST_TABLE_FULL;
      end else begin
        t_we       = 1'b1;
        tcount_nxt = tcount_r + TCW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      peak_r      <= '0;
      top_r       <= '0;
      tcount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      peak_r      <= peak_nxt;
      top_r       <= top_nxt;
      tcount_r    <= tcount_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tid_r     <= tid_nxt;
    tentry_r  <= tentry_nxt;
    tpeak_r   <= tpeak_nxt;
    tcnt_r    <= tcnt_nxt;
    status_r  <= status_nxt;
    offset_r  <= offset_nxt;
    found_r   <= found_nxt;
    e_inv_r   <= e_inv_nxt;
    e_delta_r <= e_delta_nxt;
    e_used_r  <= e_used_nxt;
    e_cnt_r   <= e_cnt_nxt;
    if (cmd.load) begin
      mode_r  <= in_data.mode;
      size_r  <= in_data.request_size;
      align_r <= in_data.alignment;
      mark_r  <= BW'(in_data.mark_value);
      id_r    <= in_data.scope_id;
      idx_r   <= '0;
      hit_r   <= 1'b0;
      rem_r   <= '0;
      dq_r    <= used_r;
      dcnt_r  <= '0;
    end
    // Restoring remainder step, one bit of usage per cycle
    if (cmd.div_step) begin
      rem_r  <= (dtrial >= dvs) ? 16'(dtrial - dvs) : dtrial[15:0];
      dq_r   <= {dq_r[BW-2:0], 1'b0};
      dcnt_r <= dcnt_r + DCW'(1);
    end
    if (cmd.exec && mode_r == MODE_END && top_r != '0) begin
      pid_r    <= tid_r;
      pentry_r <= tentry_r;
      ppeak_r  <= tpeak_r;
      pcnt_r   <= tcnt_r;
    end
    if (cmd.srch_next) begin
      idx_r <= idx_r + TCW'(1);
    end
    if (cmd.take) begin
      hit_r <= 1'b1;
    end
    if (cmd.finish) begin
      out_r.status            <= status_nxt;
      out_r.offset            <= offset_nxt;
      out_r.used_now          <= 32'(used_nxt);
      out_r.peak_now          <= 32'(peak_nxt);
      out_r.entry_found       <= found_nxt;
      out_r.invocations       <= e_inv_nxt;
      out_r.entry_peak_delta  <= e_delta_nxt;
      out_r.entry_peak_used   <= e_used_nxt;
      out_r.entry_alloc_count <= e_cnt_nxt;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  // Scope stack below the top entry
  abas_ram #(
    .WIDTH (SW),
    .DEPTH (SCOPE_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (s_we),
    .wr_addr (s_waddr),
    .wr_data (s_wdata),
    .rd_en   (s_re),
    .rd_addr (s_raddr),
    .rd_data (s_rdata)
  );

  // Telemetry table
  abas_ram #(
    .WIDTH (TW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (t_we),
    .wr_addr (t_waddr),
    .wr_data (t_wdata),
    .rd_en   (t_re),
    .rd_addr (idx_r[TAW-1:0]),
    .rd_data (t_rdata)
  );

endmodule

`default_nettype wire
